// ===== design/thp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_pkg
// Types and constants shared by the TLV header parser blocks.
// ----------------------------------------------------------------------------
package thp_pkg;

  localparam int THP_QUEUE_DEPTH = 2;
  localparam int THP_KEEP_BYTES  = 8;

  localparam logic [2:0] KIND_GENERIC  = 3'd0;
  localparam logic [2:0] KIND_PKT_SIZE = 3'd1;
  localparam logic [2:0] KIND_PORT24   = 3'd2;
  localparam logic [2:0] KIND_TSTAMP   = 3'd3;
  localparam logic [2:0] KIND_ORIG_FCS = 3'd4;
  localparam logic [2:0] KIND_PORT32   = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADLEN = 2'd1;
  localparam logic [1:0] ST_TRUNC  = 2'd2;

  localparam logic [7:0] FRONT_PORT_BASE = 8'd24;

  // One finished record, handed from the byte parser to the result stage.
  typedef struct packed {
    logic [7:0]  ftype;
    logic [7:0]  flen;
    logic        trunc;
    logic        at_end;
    logic [63:0] value;
  } thp_event_t;

endpackage

// ===== design/thp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_in_if
// Byte request channel into the TLV parser.
// ----------------------------------------------------------------------------
interface thp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       region_last;

  modport source (output valid, output data_byte, output region_last, input ready);
  modport sink   (input valid, input data_byte, input region_last, output ready);
endinterface

// ===== design/thp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_out_if
// Record result channel out of the TLV parser.
// ----------------------------------------------------------------------------
interface thp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  field_type;
  logic [7:0]  field_length;
  logic [2:0]  field_kind;
  logic [1:0]  status;
  logic [63:0] value_word;
  logic [5:0]  platform_id;
  logic [3:0]  group_id;
  logic [5:0]  box_id;
  logic [5:0]  slot_id;
  logic [9:0]  port_id;
  logic [2:0]  front_port;
  logic        region_end;

  modport source (output valid, output field_type, output field_length, output field_kind,
                  output status, output value_word, output platform_id, output group_id,
                  output box_id, output slot_id, output port_id, output front_port,
                  output region_end, input ready);
  modport sink   (input valid, input field_type, input field_length, input field_kind,
                  input status, input value_word, input platform_id, input group_id,
                  input box_id, input slot_id, input port_id, input front_port,
                  input region_end, output ready);
endinterface

// ===== design/thp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_front
// Byte parser: walks type, length and value bytes and posts finished records.
// ----------------------------------------------------------------------------
module thp_front import thp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       region_last,
  output logic       ev_valid,
  input  logic       ev_ready,
  output thp_event_t ev
);

  typedef enum logic [2:0] {
    PH_TYPE = 3'b001,
    PH_LEN  = 3'b010,
    PH_VAL  = 3'b100
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  held_type;
  logic [7:0]  held_length;
  logic [7:0]  bytes_left;
  logic [7:0]  left_dec;
  logic [63:0] value_accum, accum_next;
  logic [3:0]  kept, kept_next;
  logic        accept;
  logic        fire;

  // A byte may finish a record, so take it only when the queue has room.
  assign in_ready = ev_ready;
  assign accept   = in_valid && in_ready;
  assign left_dec = bytes_left - 8'd1;

  always_comb begin
    phase_next = phase;
    accum_next = value_accum;
    kept_next  = kept;
    fire       = 1'b0;
    ev.ftype   = held_type;
    ev.flen    = held_length;
    ev.trunc   = 1'b0;
    ev.at_end  = region_last;
    ev.value   = 64'd0;
    case (phase)
      PH_LEN: begin
        ev.flen    = data_byte;
        accum_next = 64'd0;
        kept_next  = 4'd0;
        if (data_byte == 8'd0) begin
          fire       = 1'b1;
          phase_next = PH_TYPE;
        end else if (region_last) begin
          fire       = 1'b1;
          ev.trunc   = 1'b1;
          phase_next = PH_TYPE;
        end else begin
          phase_next = PH_VAL;
        end
      end
      PH_VAL: begin
        if (kept < 4'(THP_KEEP_BYTES)) begin
          accum_next = {value_accum[55:0], data_byte};
          kept_next  = kept + 4'd1;
        end
        ev.value = accum_next;
        if (left_dec == 8'd0) begin
          fire       = 1'b1;
          phase_next = PH_TYPE;
        end else if (region_last) begin
          fire       = 1'b1;
          ev.trunc   = 1'b1;
          phase_next = PH_TYPE;
        end
      end
      default: begin
        phase_next = region_last ? PH_TYPE : PH_LEN;
      end
    endcase
  end

  assign ev_valid = accept && fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TYPE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_type   <= 8'd0;
      held_length <= 8'd0;
      bytes_left  <= 8'd0;
      value_accum <= 64'd0;
      kept        <= 4'd0;
    end else if (accept) begin
      value_accum <= accum_next;
      kept        <= kept_next;
      case (phase)
        PH_LEN: begin
          held_length <= data_byte;
          bytes_left  <= data_byte;
        end
        PH_VAL: begin
          bytes_left <= left_dec;
        end
        default: begin
          held_type <= data_byte;
        end
      endcase
    end
  end

endmodule

// ===== design/thp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_queue
// Short record queue between the byte parser and the result stage.
// ----------------------------------------------------------------------------
module thp_queue import thp_pkg::*; #(
  parameter int DEPTH = THP_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  thp_event_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output thp_event_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  thp_event_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/thp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_back
// Result stage: classifies a record, checks its length and splits port ids.
// ----------------------------------------------------------------------------
module thp_back import thp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       ev_valid,
  output logic       ev_ready,
  input  thp_event_t ev,
  thp_out_if.source  out_ch
);

  logic [2:0] kind;
  logic       len_ok;
  logic [1:0] st;
  logic [5:0] plat, box, slot;
  logic [3:0] grp;
  logic [9:0] port;
  logic [2:0] front;
  logic       take;

  assign ev_ready = !out_ch.valid || out_ch.ready;
  assign take     = ev_valid && ev_ready;

  always_comb begin
    case (ev.ftype) inside
      8'd1:         kind = KIND_PKT_SIZE;
      8'd2:         kind = KIND_PORT24;
      [8'd3:8'd6]:  kind = KIND_TSTAMP;
      8'd7:         kind = KIND_ORIG_FCS;
      8'd8:         kind = KIND_PORT32;
      default:      kind = KIND_GENERIC;
    endcase
    case (kind)
      KIND_PKT_SIZE: len_ok = (ev.flen == 8'd2);
      KIND_PORT24:   len_ok = (ev.flen == 8'd3);
      KIND_TSTAMP:   len_ok = (ev.flen == 8'd8);
      KIND_ORIG_FCS: len_ok = (ev.flen == 8'd4);
      KIND_PORT32:   len_ok = (ev.flen == 8'd4);
      default:       len_ok = 1'b1;
    endcase
    if (ev.trunc) begin
      st = ST_TRUNC;
    end else if (!len_ok) begin
      st = ST_BADLEN;
    end else begin
      st = ST_OK;
    end
    plat  = 6'd0;
    grp   = 4'd0;
    box   = 6'd0;
    slot  = 6'd0;
    port  = 10'd0;
    front = 3'd0;
    if (st == ST_OK && kind == KIND_PORT24) begin
      plat = {1'b0, ev.value[23:19]};
      grp  = ev.value[18:15];
      box  = {1'b0, ev.value[14:10]};
      port = ev.value[9:0];
      if (port >= 10'd25 && port <= 10'd28) begin
        front = 3'(port - 10'(FRONT_PORT_BASE));
      end
    end else if (st == ST_OK && kind == KIND_PORT32) begin
      plat = ev.value[31:26];
      grp  = ev.value[25:22];
      box  = ev.value[21:16];
      slot = ev.value[15:10];
      port = ev.value[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (ev_ready) begin
      out_ch.valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_ch.field_type   <= ev.ftype;
      out_ch.field_length <= ev.flen;
      out_ch.field_kind   <= kind;
      out_ch.status       <= st;
      out_ch.value_word   <= ev.value;
      out_ch.platform_id  <= plat;
      out_ch.group_id     <= grp;
      out_ch.box_id       <= box;
      out_ch.slot_id      <= slot;
      out_ch.port_id      <= port;
      out_ch.front_port   <= front;
      out_ch.region_end   <= ev.at_end;
    end
  end

endmodule

// ===== design/tap_header_tlv_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tap_header_tlv_parser_unit
// TLV region parser for a packet-broker header, one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
// The block takes one byte request per clock cycle while the queue has room,
// with region_last marking the final byte of the TLV region. That rate is
// set by the byte parser, which updates its phase, remaining count and value
// accumulator for each byte it accepts. Each finished record (including one
// cut short by the region end, reported as truncated) yields one result
// request once its final byte is accepted: the parser posts it into a queue
// of QUEUE_DEPTH records, and the result stage classifies the type, checks
// the length and splits source-port ids into a registered output. The queue
// lets the input keep flowing while a result waits on the output side; input
// is held off only when the queue is full. A type byte that is itself the
// last byte of the region produces no result.
// ----------------------------------------------------------------------------
module tap_header_tlv_parser_unit import thp_pkg::*; #(
  parameter int QUEUE_DEPTH = THP_QUEUE_DEPTH
) (
  input logic       clk,
  input logic       rst,
  thp_in_if.sink    in_ch,
  thp_out_if.source out_ch
);

  // Records travel from the parser to the queue, then to the result stage.
  logic       push_valid, push_ready;
  logic       pop_valid, pop_ready;
  thp_event_t push_data, pop_data;

  thp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .data_byte   (in_ch.data_byte),
    .region_last (in_ch.region_last),
    .ev_valid    (push_valid),
    .ev_ready    (push_ready),
    .ev          (push_data)
  );

  thp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The result stage owns the output register and its valid flag.
  thp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .ev_valid (pop_valid),
    .ev_ready (pop_ready),
    .ev       (pop_data),
    .out_ch   (out_ch)
  );

endmodule

// ===== design/thp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_checker
// Port-level checks on the TLV parser results.
// ----------------------------------------------------------------------------
module thp_checker import thp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  field_kind,
  input logic [1:0]  status,
  input logic [63:0] value_word,
  input logic [5:0]  platform_id,
  input logic [3:0]  group_id,
  input logic [5:0]  box_id,
  input logic [5:0]  slot_id,
  input logic [9:0]  port_id,
  input logic [2:0]  front_port,
  input logic        region_end
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_word) && $stable(status))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_trunc: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_TRUNC |-> region_end)
    else $error("truncated record not at region end");

  a_ids: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK || (field_kind != KIND_PORT24 && field_kind != KIND_PORT32))
    |-> platform_id == 6'd0 && group_id == 4'd0 && box_id == 6'd0 && slot_id == 6'd0
        && port_id == 10'd0 && front_port == 3'd0)
    else $error("ids set on a record that carries none");

  a_front: assert property (@(posedge clk) disable iff (rst)
    out_valid && front_port != 3'd0
    |-> field_kind == KIND_PORT24 && port_id == 10'(front_port) + 10'd24)
    else $error("front port does not match port id");

endmodule

bind tap_header_tlv_parser_unit thp_checker u_thp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .field_kind  (out_ch.field_kind),
  .status      (out_ch.status),
  .value_word  (out_ch.value_word),
  .platform_id (out_ch.platform_id),
  .group_id    (out_ch.group_id),
  .box_id      (out_ch.box_id),
  .slot_id     (out_ch.slot_id),
  .port_id     (out_ch.port_id),
  .front_port  (out_ch.front_port),
  .region_end  (out_ch.region_end)
);
